FILE: src/ngll_pkg.sv
// Shared types, character codes and digit weight tables for the GLL position parser.
package ngll_pkg;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int unsigned ID_LEN = 5;

   localparam logic [31:0] SAT_LIMIT     = 32'd2000000000;
   localparam logic [31:0] INT_SAT_LIMIT = 32'd200000000;

   // Weight position that selects the integer-digit weight
   localparam logic [2:0] POS_INTEGER = 3'd5;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_DOLLAR  = 3'd0;
   localparam kind_type KIND_COMMA   = 3'd1;
   localparam kind_type KIND_NEWLINE = 3'd2;
   localparam kind_type KIND_RETURN  = 3'd3;
   localparam kind_type KIND_TEXT    = 3'd4;

   typedef struct packed {
      kind_type   kind;
      logic       blank;
      logic       sign;
      logic       minus;
      logic       dot;
      logic       digit;
      logic [3:0] digit_val;
      logic [7:0] ch;
   } item_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
      logic       empty;
   } queue_status_type;

   function automatic logic [7:0] id_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h47; // G
         3'd1:    c = 8'h50; // P
         3'd2:    c = 8'h47; // G
         3'd3:    c = 8'h4C; // L
         3'd4:    c = 8'h4C; // L
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Digit times its place weight in units of 1e-5; positions 0..4 are decimals
   function automatic logic [19:0] digit_weight(input logic [3:0] d, input logic [2:0] pos);
      logic [19:0] w;
      case (pos)
         3'd0:    w = 20'd10000;
         3'd1:    w = 20'd1000;
         3'd2:    w = 20'd100;
         3'd3:    w = 20'd10;
         3'd4:    w = 20'd1;
         default: w = 20'd100000;
      endcase
      return 20'(20'(d) * w);
   endfunction

endpackage

FILE: src/ngll_front.sv
// Front end: classifies each received character before it enters the queue.
module ngll_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] rx_byte
   input  logic              q_ready,
   output logic              push,
   output ngll_pkg::item_type push_item
);

   logic [7:0] c;

   assign c          = req_tdata;
   assign req_tready = q_ready;
   assign push       = req_tvalid;

   always_comb begin
      push_item           = '0;
      push_item.ch        = c;
      push_item.blank     = (c == ngll_pkg::CH_SPACE) || (c == ngll_pkg::CH_TAB) ||
                            (c == ngll_pkg::CH_VT) || (c == ngll_pkg::CH_FF);
      push_item.sign      = (c == ngll_pkg::CH_PLUS) || (c == ngll_pkg::CH_MINUS);
      push_item.minus     = (c == ngll_pkg::CH_MINUS);
      push_item.dot       = (c == ngll_pkg::CH_DOT);
      push_item.digit     = (c >= ngll_pkg::CH_ZERO) && (c <= ngll_pkg::CH_NINE);
      push_item.digit_val = 4'(c - ngll_pkg::CH_ZERO);
      priority if (c == ngll_pkg::CH_DOLLAR) begin
         push_item.kind = ngll_pkg::KIND_DOLLAR;
      end else if (c == ngll_pkg::CH_COMMA) begin
         push_item.kind = ngll_pkg::KIND_COMMA;
      end else if (c == ngll_pkg::CH_LF) begin
         push_item.kind = ngll_pkg::KIND_NEWLINE;
      end else if (c == ngll_pkg::CH_CR) begin
         push_item.kind = ngll_pkg::KIND_RETURN;
      end else begin
         push_item.kind = ngll_pkg::KIND_TEXT;
      end
   end

endmodule

FILE: src/ngll_queue.sv
// Two-entry queue of classified characters between front and back end.
module ngll_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ngll_pkg::item_type        push_item,
   input  logic                      pop,
   output ngll_pkg::item_type        pop_item,
   output ngll_pkg::queue_status_type status
);

   ngll_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.count = count_ff;
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/ngll_back.sv
// Back end: sentence tracking, number accumulation and the result register.
module ngll_back #(
   parameter int FIELDS      = 8,
   parameter int FIELD_CHARS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  ngll_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata    // [31:0] latitude_fixed, [63:32] longitude_fixed
);

   localparam int FW = (FIELDS > 1) ? $clog2(FIELDS) : 1;
   localparam int CW = $clog2(FIELD_CHARS + 1);

   localparam logic [2:0] PH_LEAD = 3'd0;
   localparam logic [2:0] PH_SIGN = 3'd1;
   localparam logic [2:0] PH_INT  = 3'd2;
   localparam logic [2:0] PH_FRAC = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   logic          receiving_ff, receiving_in;
   logic [FW-1:0] field_ff, field_in;
   logic [CW-1:0] chars_ff, chars_in;
   logic          id_match_ff, id_match_in;
   logic          valid_ff, valid_in;
   logic [2:0]    phase_ff, phase_in;
   logic          neg_ff, neg_in;
   logic [2:0]    frac_ff, frac_in;
   logic [31:0]   value_ff, value_in;
   logic [31:0]   lat_ff, lat_in;
   logic [31:0]   lon_ff, lon_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;

   logic          take;
   logic [34:0]   times_ten;
   logic [31:0]   int_base;
   logic [32:0]   int_sum;
   logic [31:0]   int_next;
   logic [32:0]   frac_sum;
   logic [31:0]   frac_next;
   logic [31:0]   signed_val;
   logic          is_lat, is_lon;

   // Only a newline has to wait for a held result; other characters keep flowing
   assign take       = q_valid && (!rsp_valid_ff || rsp_tready ||
                                   q_item.kind != ngll_pkg::KIND_NEWLINE);
   assign q_pop      = take;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign is_lat = (field_ff == FW'(1));
   assign is_lon = (field_ff == FW'(3));

   // Scale by ten and add the integer digit; saturate early so the sum stays narrow
   always_comb begin
      times_ten  = {value_ff, 3'b000} + {2'b00, value_ff, 1'b0};
      int_base   = (value_ff > ngll_pkg::INT_SAT_LIMIT) ? ngll_pkg::SAT_LIMIT : times_ten[31:0];
      int_sum    = {1'b0, int_base} +
                   33'(ngll_pkg::digit_weight(q_item.digit_val, ngll_pkg::POS_INTEGER));
      int_next   = (int_sum > {1'b0, ngll_pkg::SAT_LIMIT}) ? ngll_pkg::SAT_LIMIT : int_sum[31:0];
      frac_sum   = {1'b0, value_ff} + 33'(ngll_pkg::digit_weight(q_item.digit_val, frac_ff));
      frac_next  = (frac_sum > {1'b0, ngll_pkg::SAT_LIMIT}) ? ngll_pkg::SAT_LIMIT : frac_sum[31:0];
      signed_val = neg_ff ? 32'(32'd0 - value_ff) : value_ff;
   end

   always_comb begin
      receiving_in = receiving_ff;
      field_in     = field_ff;
      chars_in     = chars_ff;
      id_match_in  = id_match_ff;
      valid_in     = valid_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      frac_in      = frac_ff;
      value_in     = value_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (take) begin
         priority if (q_item.kind == ngll_pkg::KIND_DOLLAR) begin
            receiving_in = 1'b1;
            field_in     = '0;
            id_match_in  = 1'b1;
            valid_in     = 1'b0;
            lat_in       = '0;
            lon_in       = '0;
            chars_in     = '0;
            phase_in     = PH_LEAD;
            neg_in       = 1'b0;
            frac_in      = '0;
            value_in     = '0;
         end else if (!receiving_ff || q_item.kind == ngll_pkg::KIND_RETURN) begin
            receiving_in = receiving_ff;
         end else if (q_item.kind == ngll_pkg::KIND_COMMA) begin
            if (field_ff == '0) begin
               valid_in = id_match_ff && (chars_ff >= CW'(ngll_pkg::ID_LEN));
            end else if (is_lat) begin
               lat_in = signed_val;
            end else if (is_lon) begin
               lon_in = signed_val;
            end
            // Drop the sentence when field 0 is not the expected id
            if (field_ff == '0 && !(id_match_ff && (chars_ff >= CW'(ngll_pkg::ID_LEN)))) begin
               receiving_in = 1'b0;
            end else begin
               if (field_ff < FW'(FIELDS - 1)) begin
                  field_in = FW'(field_ff + FW'(1));
               end
               chars_in = '0;
               phase_in = PH_LEAD;
               neg_in   = 1'b0;
               frac_in  = '0;
               value_in = '0;
            end
         end else if (q_item.kind == ngll_pkg::KIND_NEWLINE) begin
            receiving_in = 1'b0;
            if (valid_ff && field_ff != '0) begin
               if (is_lat) begin
                  lat_in = signed_val;
               end else if (is_lon) begin
                  lon_in = signed_val;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(is_lon ? signed_val : lon_ff), (is_lat ? signed_val : lat_ff)};
            end
         end else if (chars_ff < CW'(FIELD_CHARS)) begin
            chars_in = CW'(chars_ff + CW'(1));
            if (field_ff == '0) begin
               if (chars_ff < CW'(ngll_pkg::ID_LEN) &&
                   q_item.ch != ngll_pkg::id_char(chars_ff[2:0])) begin
                  id_match_in = 1'b0;
               end
            end else if (is_lat || is_lon) begin
               unique case (phase_ff)
                  PH_LEAD, PH_SIGN, PH_INT: begin
                     if (phase_ff == PH_LEAD && q_item.blank) begin
                        phase_in = PH_LEAD;
                     end else if (phase_ff == PH_LEAD && q_item.sign) begin
                        neg_in   = q_item.minus;
                        phase_in = PH_SIGN;
                     end else if (q_item.digit) begin
                        value_in = int_next;
                        phase_in = PH_INT;
                     end else if (q_item.dot) begin
                        phase_in = PH_FRAC;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_FRAC: begin
                     if (q_item.digit) begin
                        // Keep five decimals, consume the rest
                        if (frac_ff < 3'd5) begin
                           value_in = frac_next;
                           frac_in  = 3'(frac_ff + 3'd1);
                        end
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         field_ff     <= '0;
         chars_ff     <= '0;
         id_match_ff  <= 1'b1;
         valid_ff     <= 1'b0;
         phase_ff     <= PH_LEAD;
         neg_ff       <= 1'b0;
         frac_ff      <= '0;
         value_ff     <= '0;
         lat_ff       <= '0;
         lon_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         receiving_ff <= receiving_in;
         field_ff     <= field_in;
         chars_ff     <= chars_in;
         id_match_ff  <= id_match_in;
         valid_ff     <= valid_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         frac_ff      <= frac_in;
         value_ff     <= value_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: src/nmea_gll_position_parser.sv
// A character transfer is written into a queue entry register, which the back end reads;
// the result caused by a newline is registered and drives rsp_tvalid.
// Throughput: one character per cycle while the queue has room, set by the accumulate
// step in the back end; only a newline waits on a held result, which the queue absorbs.
// Reset: synchronous, active high; the parser waits for a dollar sign and the queue
// and result register empty.
module nmea_gll_position_parser #(
   parameter int FIELDS      = 8,
   parameter int FIELD_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] latitude_fixed, [63:32] longitude_fixed
);

   logic                       push;
   ngll_pkg::item_type         push_item;
   logic                       pop;
   ngll_pkg::item_type         pop_item;
   ngll_pkg::queue_status_type q_status;

   ngll_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_ready    (!q_status.full),
      .push       (push),
      .push_item  (push_item)
   );

   ngll_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   ngll_back #(
      .FIELDS      (FIELDS),
      .FIELD_CHARS (FIELD_CHARS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_status.empty),
      .q_item     (pop_item),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count != 2'd3)
      else $error("queue count out of range");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_status.count == 2'd2)
      else $error("input stalled while queue has room");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pop))
      else $error("result appeared without a queue transfer");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

endmodule
